@@ hdl/hvc_pkg.sv @@
// Shared types, constants and helpers for the heating valve controller.
// No dependencies; used by hvc_valve.sv and heating_valve_controller_core.sv.

package hvc_pkg;

  // Valve phases
  localparam logic [1:0] PH_CLOSED  = 2'd0;
  localparam logic [1:0] PH_OPENING = 2'd1;
  localparam logic [1:0] PH_OPENED  = 2'd2;
  localparam logic [1:0] PH_CLOSING = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ROOM_SETPOINT   = 3'd0;
  localparam logic [2:0] REG_BAND_HALF_WIDTH = 3'd1;
  localparam logic [2:0] REG_OPEN_ANGLE      = 3'd2;
  localparam logic [2:0] REG_CLOSE_ANGLE     = 3'd3;
  localparam logic [2:0] REG_CLOSE_DELAY     = 3'd4;

  localparam int unsigned TEMP_W  = 11;
  localparam int unsigned DEG_W   = 8;
  localparam int unsigned ANGLE_W = 14;
  localparam int unsigned DELAY_W = 17;
  localparam int unsigned CFG_W   = 17;

  localparam logic [7:0]         SETPOINT_RST  = 8'd22;
  localparam logic [7:0]         DEVIATION_RST = 8'd2;
  localparam logic [DELAY_W-1:0] CLOSE_WAIT_RST = 17'd50000;

  // Condition flags handed to the valve machine
  typedef struct packed {
    logic water_cold;
    logic water_hot;
    logic room_cold;
    logic room_hot;
    logic at_open;
    logic at_close;
  } flags_t;

  // One result beat
  typedef struct packed {
    logic [1:0] phase;
    logic       step;
    logic       dir_open;
    logic       enable;
    logic       pump;
  } result_t;

  // Tenths to whole degrees, rounded: (t + 5) / 10.
  // x * 6554 >> 16 equals x / 10 exactly for x < 16384; x is at most 2052.
  function automatic logic [DEG_W-1:0] whole_degrees(input logic [TEMP_W-1:0] tenths);
    logic [TEMP_W:0]    x;
    logic [TEMP_W+13:0] prod;
    begin
      x    = {1'b0, tenths} + 12'd5;
      prod = {13'd0, x} * 25'd6554;
      whole_degrees = prod[23:16];
    end
  endfunction

endpackage

@@ hdl/hvc_valve.sv @@
// Valve phase machine: holds phase, pump/enable/direction levels and the close delay.
// Depends on hvc_pkg.

module hvc_valve (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  hvc_pkg::flags_t                flags,
  input  logic [hvc_pkg::DELAY_W-1:0]    close_delay_ticks,
  output hvc_pkg::result_t               result_next
);

  logic [1:0]                    phase, phase_next;
  logic                          pump, pump_next;
  logic                          enable, enable_next;
  logic                          dir_open, dir_open_next;
  logic [hvc_pkg::DELAY_W-1:0]   close_wait, close_wait_next;
  logic                          step;

  always_comb begin
    phase_next      = phase;
    pump_next       = pump;
    enable_next     = enable;
    dir_open_next   = dir_open;
    close_wait_next = close_wait;
    step            = 1'b0;
    case (phase)
      hvc_pkg::PH_CLOSED: begin
        if (flags.water_hot) begin
          pump_next     = 1'b0;
          dir_open_next = 1'b1;
          enable_next   = 1'b1;
          phase_next    = hvc_pkg::PH_OPENING;
        end else begin
          enable_next = 1'b0;
        end
      end
      hvc_pkg::PH_OPENED: begin
        if (flags.water_cold) begin
          pump_next = 1'b0;
          if (close_wait != '0) begin
            close_wait_next = close_wait - 1'b1;
          end else begin
            dir_open_next   = 1'b0;
            enable_next     = 1'b1;
            phase_next      = hvc_pkg::PH_CLOSING;
            close_wait_next = close_delay_ticks;
          end
        end else if (flags.room_hot) begin
          enable_next = 1'b0;
          pump_next   = 1'b0;
        end else if (flags.room_cold) begin
          enable_next = 1'b0;
          pump_next   = 1'b1;
        end
      end
      hvc_pkg::PH_OPENING: begin
        if (!flags.at_open) step = 1'b1;
        else phase_next = hvc_pkg::PH_OPENED;
      end
      default: begin
        if (!flags.at_close) step = 1'b1;
        else phase_next = hvc_pkg::PH_CLOSED;
      end
    endcase
  end

  assign result_next = '{phase: phase_next, step: step, dir_open: dir_open_next,
                         enable: enable_next, pump: pump_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= hvc_pkg::PH_CLOSED;
      pump       <= 1'b0;
      enable     <= 1'b0;
      dir_open   <= 1'b0;
      close_wait <= hvc_pkg::CLOSE_WAIT_RST;
    end else if (fire) begin
      phase      <= phase_next;
      pump       <= pump_next;
      enable     <= enable_next;
      dir_open   <= dir_open_next;
      close_wait <= close_wait_next;
    end
  end

endmodule

@@ hdl/heating_valve_controller_core.sv @@
// Pipeline: input beat to result beat through the input register, then the result register.
// Throughput: one beat per cycle; the input register moves on when the result
// register is free or its beat leaves in the same cycle.
// Reset (rst, synchronous): pipeline emptied, registers back to defaults,
// valve closed, pump/enable/direction low, close delay 50000 ticks.
// Top level; depends on hvc_pkg and hvc_valve.

module heating_valve_controller_core (
  input  logic        clk,
  input  logic        rst,
  // Input beat: [10:0] room_temp_tenths, [21:11] water_temp_tenths,
  // [35:22] valve_angle, [39:36] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // Result beat: [0] pump_on, [1] motor_enable, [2] motor_dir_open,
  // [3] step_pulse, [5:4] valve_phase, [7:6] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  // Configuration writes
  input  logic                      cfg_wen,
  input  logic [2:0]                cfg_index,
  input  logic [hvc_pkg::CFG_W-1:0] cfg_data
);

  // Configuration registers
  logic [7:0]                    room_setpoint;
  logic [7:0]                    band_half_width;
  logic [hvc_pkg::ANGLE_W-1:0]   open_angle;
  logic [hvc_pkg::ANGLE_W-1:0]   close_angle;
  logic [hvc_pkg::DELAY_W-1:0]   close_delay_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_setpoint     <= hvc_pkg::SETPOINT_RST;
      band_half_width   <= hvc_pkg::DEVIATION_RST;
      open_angle        <= '0;
      close_angle       <= '0;
      close_delay_ticks <= hvc_pkg::CLOSE_WAIT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        hvc_pkg::REG_ROOM_SETPOINT:   room_setpoint     <= cfg_data[7:0];
        hvc_pkg::REG_BAND_HALF_WIDTH: band_half_width   <= cfg_data[7:0];
        hvc_pkg::REG_OPEN_ANGLE:      open_angle        <= cfg_data[13:0];
        hvc_pkg::REG_CLOSE_ANGLE:     close_angle       <= cfg_data[13:0];
        hvc_pkg::REG_CLOSE_DELAY:     close_delay_ticks <= cfg_data[16:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // Stage handshake: each stage advances when empty or when the next one advances
  logic in_valid;
  logic adv_out, adv_in;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv_in   = !in_valid || adv_out;
  assign s_tready = adv_in;

  // Stage 1: raw input register
  logic [hvc_pkg::TEMP_W-1:0]  room_raw, water_raw;
  logic [hvc_pkg::ANGLE_W-1:0] angle_raw;

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (adv_in) in_valid <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv_in && s_tvalid) begin
      room_raw  <= s_tdata[10:0];
      water_raw <= s_tdata[21:11];
      angle_raw <= s_tdata[35:22];
    end
  end

  // Round to whole degrees, compare signed against the band.
  // Band limits span -255..510, so 10-bit signed covers them.
  logic [7:0]          room_deg, water_deg;
  logic signed [9:0]   low_bound, high_bound, room_s, water_s;
  hvc_pkg::flags_t     flags;

  always_comb begin
    room_deg   = hvc_pkg::whole_degrees(room_raw);
    water_deg  = hvc_pkg::whole_degrees(water_raw);
    room_s     = signed'({2'b00, room_deg});
    water_s    = signed'({2'b00, water_deg});
    low_bound  = signed'({2'b00, room_setpoint}) - signed'({2'b00, band_half_width});
    high_bound = signed'({2'b00, room_setpoint}) + signed'({2'b00, band_half_width});
    flags.water_cold = water_s < low_bound;
    flags.water_hot  = water_s > high_bound;
    flags.room_cold  = room_s < low_bound;
    flags.room_hot   = room_s > high_bound;
    flags.at_open    = angle_raw == open_angle;
    flags.at_close   = angle_raw == close_angle;
  end

  // Stage 2: valve machine updates its state as the result is registered
  logic             fire;
  hvc_pkg::result_t result_next, result;

  assign fire = adv_out && in_valid;

  hvc_valve u_valve (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .flags             (flags),
    .close_delay_ticks (close_delay_ticks),
    .result_next       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv_out) m_tvalid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (fire) result <= result_next;
  end

  assign m_tdata = {2'b00, result.phase, result.step, result.dir_open,
                    result.enable, result.pump};

endmodule

@@ tb/sv/hvc_checker.sv @@
`timescale 1ns / 1ps
// Result checker for heating_valve_controller_core: mirrors the valve machine,
// queues the predicted result beats and compares them. Depends on hvc_pkg.

module hvc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          results_seen
);

  localparam int MAX_REPORTS = 100;

  // register copies
  logic [7:0]  setpoint;
  logic [7:0]  deviation;
  logic [13:0] open_pos;
  logic [13:0] close_pos;
  logic [16:0] delay_reload;

  // valve machine copy
  logic [1:0]  valve_phase;
  logic        pump;
  logic        enable;
  logic        dir_open;
  logic [16:0] cold_wait;

  hvc_pkg::result_t valve_outputs_q[$];
  hvc_pkg::result_t wanted;
  hvc_pkg::result_t actual;

  task automatic report_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (want !== got) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // One control tick of the valve machine.
  task automatic run_control_tick(input logic [39:0] beat, output hvc_pkg::result_t res);
    int   room_deg;
    int   water_deg;
    int   lo;
    int   hi;
    logic step;
    begin
      room_deg  = (int'(beat[10:0]) + 5) / 10;
      water_deg = (int'(beat[21:11]) + 5) / 10;
      lo = int'(setpoint) - int'(deviation);
      hi = int'(setpoint) + int'(deviation);
      step = 1'b0;
      case (valve_phase)
        hvc_pkg::PH_CLOSED: begin
          if (water_deg > hi) begin
            pump = 1'b0;
            dir_open = 1'b1;
            enable = 1'b1;
            valve_phase = hvc_pkg::PH_OPENING;
          end else begin
            enable = 1'b0;
          end
        end
        hvc_pkg::PH_OPENED: begin
          if (water_deg < lo) begin
            pump = 1'b0;
            if (cold_wait != '0) begin
              cold_wait = cold_wait - 17'd1;
            end else begin
              dir_open = 1'b0;
              enable = 1'b1;
              valve_phase = hvc_pkg::PH_CLOSING;
              cold_wait = delay_reload;
            end
          end else if (room_deg > hi) begin
            enable = 1'b0;
            pump = 1'b0;
          end else if (room_deg < lo) begin
            enable = 1'b0;
            pump = 1'b1;
          end
        end
        hvc_pkg::PH_OPENING: begin
          if (beat[35:22] != open_pos) step = 1'b1;
          else valve_phase = hvc_pkg::PH_OPENED;
        end
        default: begin
          if (beat[35:22] != close_pos) step = 1'b1;
          else valve_phase = hvc_pkg::PH_CLOSED;
        end
      endcase
      res.pump     = pump;
      res.enable   = enable;
      res.dir_open = dir_open;
      res.step     = step;
      res.phase    = valve_phase;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      setpoint     = hvc_pkg::SETPOINT_RST;
      deviation    = hvc_pkg::DEVIATION_RST;
      open_pos     = '0;
      close_pos    = '0;
      delay_reload = hvc_pkg::CLOSE_WAIT_RST;
      valve_phase  = hvc_pkg::PH_CLOSED;
      pump         = 1'b0;
      enable       = 1'b0;
      dir_open     = 1'b0;
      cold_wait    = hvc_pkg::CLOSE_WAIT_RST;
      valve_outputs_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          hvc_pkg::REG_ROOM_SETPOINT:   setpoint     = cfg_data[7:0];
          hvc_pkg::REG_BAND_HALF_WIDTH: deviation    = cfg_data[7:0];
          hvc_pkg::REG_OPEN_ANGLE:      open_pos     = cfg_data[13:0];
          hvc_pkg::REG_CLOSE_ANGLE:     close_pos    = cfg_data[13:0];
          hvc_pkg::REG_CLOSE_DELAY:     delay_reload = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        actual = m_tdata[5:0];
        if (valve_outputs_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: result beat %h with nothing expected", $time, m_tdata);
          errors++;
        end else begin
          wanted = valve_outputs_q.pop_front();
          report_field("pump_on", wanted.pump, actual.pump);
          report_field("motor_enable", wanted.enable, actual.enable);
          report_field("motor_dir_open", wanted.dir_open, actual.dir_open);
          report_field("step_pulse", wanted.step, actual.step);
          report_field("valve_phase", wanted.phase, actual.phase);
          report_field("tdata padding", 2'd0, m_tdata[7:6]);
        end
      end
      if (s_tvalid && s_tready) begin
        run_control_tick(s_tdata, wanted);
        valve_outputs_q.push_back(wanted);
      end
    end
    pending = valve_outputs_q.size();
  end

endmodule

@@ tb/sv/heating_valve_controller_core_tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for heating_valve_controller_core; prediction and
// comparison live in hvc_checker. Depends on hvc_pkg, the RTL and hvc_checker.

module heating_valve_controller_core_tb;

  // Index past the end of the register file: writes to it must be dropped
  localparam logic [2:0] REG_SPARE  = 3'd7;
  localparam int         LATENCY    = 2;
  localparam int         MAX_GAP    = 8;
  // Receiver hold-off, long enough to back the pipeline up into s_tready
  localparam int         HOLD_OFF   = 64;
  // Cold ticks at full rate that run the close delay partway down
  localparam int         COLD_SPELL = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_wen;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  int errors;
  int pending;
  int results_seen;
  int beats_sent;
  int settings_run;

  // When set, both sides run back to back with no idle cycles, apart from the receiver hold-offs
  bit quiet;

  // Register values currently programmed, used only to steer the stimulus
  int          sp_now;
  int          dev_now;
  logic [13:0] open_now;
  logic [13:0] close_now;

  heating_valve_controller_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  hvc_checker valve_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Temperature in tenths, steered towards the edges of the band: just cold,
  // just hot, exactly on a bound, anywhere on the scale, or any 11-bit pattern.
  function automatic logic [10:0] draw_tenths();
    int lo;
    int hi;
    int deg;
    int t;
    lo = sp_now - dev_now;
    hi = sp_now + dev_now;
    case ($urandom_range(0, 9))
      0, 1, 2: deg = lo - int'($urandom_range(1, 3));
      3, 4, 5: deg = hi + int'($urandom_range(1, 3));
      6:       deg = lo;
      7:       deg = hi;
      8: begin
        t = $urandom;
        return t[10:0];
      end
      default: deg = $urandom_range(0, 205);
    endcase
    if (deg < 0) deg = 0;
    if (deg > 205) deg = 205;
    // any value within +-0.5 degree rounds to deg
    t = deg * 10 + int'($urandom_range(0, 9)) - 5;
    if (t < 0) t = 0;
    if (t > 2047) t = 2047;
    return t[10:0];
  endfunction

  // Angle reading: often exactly at an end stop so that moves complete,
  // sometimes one count off, otherwise anything.
  function automatic logic [13:0] draw_angle();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: return open_now;
      3, 4, 5: return close_now;
      6:       return open_now + 14'd1;
      7:       return close_now - 14'd1;
      default: return r[13:0];
    endcase
  endfunction

  // Offer one tick and hold it until the block takes it. s_tready is looked
  // at on the falling edge, where it is settled for the coming rising edge.
  task automatic send_tick(input logic [10:0] room, input logic [10:0] water,
                           input logic [13:0] angle);
    int gap;
    bit seen;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, angle, water, room};
    do begin
      @(negedge clk);
      seen = s_tready;
      @(posedge clk);
    end while (!seen);
    beats_sent++;
  endtask

  // Drop valid, let every expected beat come back, then let the pipeline
  // settle before touching the registers.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Write all five registers in consecutive cycles, junk above each
  // register's width, and finish with a write to the unused index.
  task automatic program_valve(input logic [7:0] sp, input logic [7:0] dev,
                               input logic [13:0] oa, input logic [13:0] ca,
                               input logic [16:0] delay_ticks);
    logic [16:0] junk;
    junk = 17'($urandom);
    cfg_wen   <= 1'b1;
    cfg_index <= hvc_pkg::REG_ROOM_SETPOINT;
    cfg_data  <= {junk[16:8], sp};
    @(posedge clk);
    cfg_index <= hvc_pkg::REG_BAND_HALF_WIDTH;
    cfg_data  <= {junk[15:7], dev};
    @(posedge clk);
    cfg_index <= hvc_pkg::REG_OPEN_ANGLE;
    cfg_data  <= {junk[16:14], oa};
    @(posedge clk);
    cfg_index <= hvc_pkg::REG_CLOSE_ANGLE;
    cfg_data  <= {junk[2:0], ca};
    @(posedge clk);
    cfg_index <= hvc_pkg::REG_CLOSE_DELAY;
    cfg_data  <= delay_ticks;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= junk;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sp_now    = sp;
    dev_now   = dev;
    open_now  = oa;
    close_now = ca;
    settings_run++;
  endtask

  // Random ticks; every 50 beats a coin decides whether the next stretch
  // runs without idle cycles.
  task automatic random_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_tick(draw_tenths(), draw_tenths(), draw_angle());
    end
  endtask

  // Result side: a random wait per beat, except for two long hold-offs that
  // let the block fill up while the sender keeps offering.
  initial begin : receiver
    int gap;
    int taken;
    bit seen;
    m_tready = 1'b0;
    taken = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (taken == 400 || taken == 800) gap = HOLD_OFF;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        seen = m_tvalid;
        @(posedge clk);
      end while (!seen);
      taken++;
    end
  end

  // Generous overall limit, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("Timeout: results still outstanding (%0d)", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wen   = 1'b0;
    cfg_index = hvc_pkg::REG_ROOM_SETPOINT;
    cfg_data  = '0;
    quiet     = 1'b0;
    beats_sent   = 0;
    settings_run = 0;
    // reset register values: band 20..24 degrees, both end stops at 0
    sp_now    = hvc_pkg::SETPOINT_RST;
    dev_now   = hvc_pkg::DEVIATION_RST;
    open_now  = '0;
    close_now = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk through the valve cycle at reset settings
    send_tick(11'd0, 11'd0, 14'd0);          // closed, cold water: enable off
    send_tick(11'd2047, 11'd2047, 14'd16383); // hot water, largest codes: start opening
    send_tick(11'd244, 11'd244, 14'd16383);   // opening, off target: step
    send_tick(11'd1, 11'd1, 14'd16382);       // still stepping
    send_tick(11'd220, 11'd220, 14'd0);       // reaches open stop: opened
    send_tick(11'd2047, 11'd220, 14'd8191);   // room hot: pump and enable off
    send_tick(11'd0, 11'd220, 14'd0);         // room cold: pump on
    send_tick(11'd220, 11'd220, 14'd0);       // all in band: levels held
    send_tick(11'd245, 11'd195, 14'd0);       // room rounds to 25, just hot; water on low bound
    send_tick(11'd194, 11'd244, 14'd0);       // room rounds to 19, just cold; water on high bound
    send_tick(11'd220, 11'd194, 14'd0);       // water just cold: close delay counts down
    send_tick(11'd220, 11'd2047, 14'd0);      // water warm again: delay is not reloaded
    send_tick(11'd220, 11'd0, 14'd0);         // cold again: count carries on
    send_tick(11'd0, 11'd0, 14'd0);           // cold water wins over cold room

    // Short cold spell at full rate; the delay keeps counting down
    quiet = 1'b1;
    for (int i = 0; i < COLD_SPELL; i++)
      send_tick(draw_tenths(), 11'd0, 14'd5);
    quiet = 1'b0;
    send_tick(11'd220, 11'd0, 14'd0);         // still cold: count goes on
    send_tick(11'd220, 11'd2047, 14'd0);      // hot water while opened: levels held
    send_tick(11'd220, 11'd220, 14'd0);       // all in band
    drain_pipeline();

    // Random phases across several settings, extremes among them
    program_valve(8'd22, 8'd2, 14'd1000, 14'd200, 17'd3);
    random_ticks(200);
    drain_pipeline();
    program_valve(8'd0, 8'd0, 14'd0, 14'd16383, 17'd0);
    random_ticks(150);
    drain_pipeline();
    program_valve(8'd255, 8'd255, 14'd16383, 14'd0, 17'd1);
    random_ticks(150);
    drain_pipeline();
    // setpoint below the deviation: low bound negative
    program_valve(8'd10, 8'd40, 14'($urandom), 14'($urandom), 17'd5);
    random_ticks(150);
    drain_pipeline();
    program_valve(8'($urandom_range(0, 205)), 8'($urandom_range(0, 7)),
                  14'($urandom), 14'($urandom), 17'd131071);
    random_ticks(150);
    drain_pipeline();
    program_valve(8'd60, 8'd3, 14'($urandom), 14'($urandom), 17'd2);
    random_ticks(200);
    drain_pipeline();
    program_valve(8'd30, 8'd1, 14'd0, 14'd0, 17'd4);
    random_ticks(150);

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d ticks and checked %0d result beats over %0d register settings,",
             beats_sent, results_seen, settings_run);
    $display("including a %0d-tick cold spell and two long receiver stalls.", COLD_SPELL);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
